// ===== sv/image_smoother_3x3_core_macros.svh =====
// Assertion macros shared by the smoother checker.
`ifndef IMAGE_SMOOTHER_3X3_CORE_MACROS_SVH
`define IMAGE_SMOOTHER_3X3_CORE_MACROS_SVH

// Overlapping implication, checked at every clock edge outside reset.
`define IMS_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ims check failed");

// Implication into the next cycle.
`define IMS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ims check failed");

`endif

// ===== sv/ims_pkg.sv =====
// Shared constants, types and the reciprocal table of the 3x3 smoother.
package ims_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIX_W      = 8;
	localparam int CNT_W      = 9;                      // config and counter width
	localparam int COL_W      = $clog2(MAX_WIDTH);      // line store address
	localparam int SUM_W      = 12;                     // nine 8-bit samples
	localparam int NUM_W      = 4;                      // neighbor count 0..9
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 16;
	localparam int PROD_W     = SUM_W + RECIP_W;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic accept;
		logic shift;
		logic sum;
		logic mul;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic out_free;
	} stat_t;

	// ceil(2^16 / n); exact floor for sums up to 9*255
	function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1: r = 17'd65536;
			4'd2: r = 17'd32768;
			4'd3: r = 17'd21846;
			4'd4: r = 17'd16384;
			4'd5: r = 17'd13108;
			4'd6: r = 17'd10923;
			4'd7: r = 17'd9363;
			4'd8: r = 17'd8192;
			4'd9: r = 17'd7282;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/ims_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ims_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/ims_ctrl.sv =====
// Controller: sequences one item: read, window shift; if primed sum, scale, output.
module ims_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ims_pkg::stat_t stat,
	output ims_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.shift = 1'b1;
				state_d   = stat.primed ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free or being drained
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/ims_dpath.sv =====
// Datapath: line stores, 3x3 window, position counters, averaging and output register.
module ims_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_addr,
	input  logic [ims_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                        kind,
	input  logic [ims_pkg::PIX_W-1:0]   pixel,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [ims_pkg::PIX_W-1:0]   smoothed,
	output logic                        last_of_frame,
	input  ims_pkg::cmd_t               cmd,
	output ims_pkg::stat_t              stat
);

	logic [ims_pkg::CNT_W-1:0]    width_cfg_q, height_cfg_q;
	logic [ims_pkg::CNT_W-1:0]    w, h;
	logic [ims_pkg::CNT_W-1:0]    in_col_q, in_row_q, out_col_q, out_row_q;
	logic [ims_pkg::COL_W-1:0]    col;
	logic [ims_pkg::PIX_W-1:0]    sample_q;
	logic [ims_pkg::PIX_W-1:0]    top_rd, mid_rd;
	logic [ims_pkg::PIX_W-1:0]    win_q [9];
	logic [2:0]                   rv, cv;
	logic [ims_pkg::SUM_W-1:0]    sum_d, sum_q;
	logic [ims_pkg::NUM_W-1:0]    num_d, num_q;
	logic [ims_pkg::PROD_W-1:0]   prod_q;
	logic [ims_pkg::CNT_W:0]      in_col_p1, out_col_p1, out_row_p1;
	logic                         in_wrap, out_wrap, last;
	logic                         out_valid_q, last_q;
	logic [ims_pkg::PIX_W-1:0]    smoothed_q;

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (width_cfg_q == '0)
			w = ims_pkg::CNT_W'(1);
		else if (width_cfg_q > ims_pkg::CNT_W'(ims_pkg::MAX_WIDTH))
			w = ims_pkg::CNT_W'(ims_pkg::MAX_WIDTH);
		else
			w = width_cfg_q;
		if (height_cfg_q == '0)
			h = ims_pkg::CNT_W'(1);
		else if (height_cfg_q > ims_pkg::CNT_W'(ims_pkg::MAX_HEIGHT))
			h = ims_pkg::CNT_W'(ims_pkg::MAX_HEIGHT);
		else
			h = height_cfg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= ims_pkg::CNT_W'(256);
			height_cfg_q <= ims_pkg::CNT_W'(256);
		end else if (cfg_we) begin
			case (cfg_addr)
				ims_pkg::REG_FRAME_WIDTH:  width_cfg_q  <= cfg_wdata;
				ims_pkg::REG_FRAME_HEIGHT: height_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign col = (in_col_q < ims_pkg::CNT_W'(ims_pkg::MAX_WIDTH)) ?
		in_col_q[ims_pkg::COL_W-1:0] : ims_pkg::COL_W'(ims_pkg::MAX_WIDTH - 1);

	// mid store holds the previous row, top store the row before it
	ims_ram #(.WIDTH(ims_pkg::PIX_W), .DEPTH(ims_pkg::MAX_WIDTH)) u_top_ram (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (col),
		.wdata (mid_rd),
		.raddr (col),
		.rdata (top_rd)
	);

	ims_ram #(.WIDTH(ims_pkg::PIX_W), .DEPTH(ims_pkg::MAX_WIDTH)) u_mid_ram (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (col),
		.wdata (sample_q),
		.raddr (col),
		.rdata (mid_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= kind ? '0 : pixel;
		end
	end

	assign stat.primed = (in_row_q >= ims_pkg::CNT_W'(2)) ||
		((in_row_q == ims_pkg::CNT_W'(1)) && (in_col_q != '0));
	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= top_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= sample_q;
		end
	end

	assign in_col_p1  = {1'b0, in_col_q} + 1'b1;
	assign out_col_p1 = {1'b0, out_col_q} + 1'b1;
	assign out_row_p1 = {1'b0, out_row_q} + 1'b1;
	assign in_wrap    = in_col_p1 >= {1'b0, w};
	assign out_wrap   = out_col_p1 >= {1'b0, w};
	assign last       = out_wrap && (out_row_p1 >= {1'b0, h});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.shift) begin
			if (in_wrap) begin
				in_col_q <= '0;
				if (in_row_q < ims_pkg::CNT_W'(ims_pkg::MAX_HEIGHT + 2))
					in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_p1[ims_pkg::CNT_W-1:0];
			end
		end else if (cmd.load_out) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (out_wrap) begin
				out_col_q <= '0;
				out_row_q <= out_row_p1[ims_pkg::CNT_W-1:0];
			end else begin
				out_col_q <= out_col_p1[ims_pkg::CNT_W-1:0];
			end
		end
	end

	// in-frame rows and columns around the output position
	assign rv[0] = (out_row_q != '0) && (out_row_q <= h);
	assign rv[1] = out_row_q < h;
	assign rv[2] = out_row_p1 < {1'b0, h};
	assign cv[0] = (out_col_q != '0) && (out_col_q <= w);
	assign cv[1] = out_col_q < w;
	assign cv[2] = out_col_p1 < {1'b0, w};

	always_comb begin
		sum_d = '0;
		num_d = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (rv[r] && cv[c]) begin
					sum_d = sum_d + ims_pkg::SUM_W'(win_q[r*3+c]);
					num_d = num_d + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_q <= sum_d;
			num_q <= num_d;
		end
		if (cmd.mul) begin
			prod_q <= ims_pkg::PROD_W'(sum_q) * ims_pkg::PROD_W'(ims_pkg::recip(num_q));
		end
		if (cmd.load_out) begin
			smoothed_q <= prod_q[ims_pkg::RECIP_SH +: ims_pkg::PIX_W];
			last_q     <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign smoothed      = smoothed_q;
	assign last_of_frame = last_q;

endmodule

// ===== sv/image_smoother_3x3_core.sv =====
// Streaming 3x3 mean filter over a raster frame, one item at a time.
// An item with no result passes through accept and the line store read only; one with a
// result also passes through the window sum, the reciprocal multiply and the output load.
// A result shows on m_tvalid once the output register is loaded; a waiting result
// does not block acceptance until the next result is ready to load.
// arst_n clears counters, window and the output valid; sizes reset to 256x256.
module image_smoother_3x3_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_addr,
	input  logic [ims_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] pixel
	input  logic                      s_tuser,   // [0] kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,   // [7:0] smoothed
	output logic                      m_tlast
);

	ims_pkg::cmd_t  cmd;
	ims_pkg::stat_t stat;

	ims_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ims_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.kind          (s_tuser),
		.pixel         (s_tdata),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.smoothed      (m_tdata),
		.last_of_frame (m_tlast),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

// ===== sv/ims_checker.sv =====
// Port-level checks on the smoother, bound to the top level.
`include "image_smoother_3x3_core_macros.svh"

module ims_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [7:0]                m_tdata,
	input logic                      m_tlast
);

	`IMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`IMS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// after an accept, s_tready stays low while the item is worked on
	`IMS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// a new result only appears at the end of a busy stretch
	`IMS_ASSERT_SAME(a_result_after_work, $rose(m_tvalid), $past(!s_tready))

endmodule

bind image_smoother_3x3_core ims_checker u_ims_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming 3x3 mean filter core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ims_pkg::*;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;
	localparam int   MISMATCH_SHOWN = 10;

	typedef struct packed {
		logic [7:0] smoothed;
		logic       last;
	} blur_px_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_addr = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;

	// shadow of the block: sizes, line stores, window, counters
	logic [CNT_W-1:0] frame_w_reg = 9'd256;
	logic [CNT_W-1:0] frame_h_reg = 9'd256;
	logic [7:0]       line_mem [2*MAX_WIDTH];
	logic [7:0]       win [9];
	int unsigned      in_col = 0;
	int unsigned      in_row = 0;
	int unsigned      out_col = 0;
	int unsigned      out_row = 0;

	blur_px_t         expected_pixels [$];
	blur_px_t         oldest_px;
	int unsigned      frames_done = 0;
	int unsigned      items_sent = 0;
	int unsigned      mismatches = 0;

	bit               tx_idle_en = 1'b0;
	bit               rx_idle_en = 1'b0;
	int unsigned      rx_hold = 0;

	image_smoother_3x3_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] pixel
		.s_tuser  (s_tuser),   // [0] kind
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] smoothed
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	initial begin
		foreach (line_mem[i]) line_mem[i] = '0;
		foreach (win[i]) win[i] = '0;
	end

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bit cell_in_frame(input int unsigned pos, input int delta,
			input int unsigned size);
		if (delta < 0) return pos >= 1 && pos - 1 < size;
		if (delta > 0) return pos + 1 < size;
		return pos < size;
	endfunction

	function automatic void predict_blur(input logic kind, input logic [7:0] pix);
		int unsigned w, h, col, sum, cnt;
		logic [7:0]  sample, top, mid;
		logic [7:0]  fresh [3];
		bit          primed, last;
		blur_px_t    px;
		w = clamp_size(frame_w_reg, MAX_WIDTH);
		h = clamp_size(frame_h_reg, MAX_HEIGHT);
		sample = (kind == KIND_FLUSH) ? 8'd0 : pix;
		primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
		col = in_col < MAX_WIDTH ? in_col : MAX_WIDTH - 1;
		top = line_mem[MAX_WIDTH + col];
		mid = line_mem[col];
		line_mem[MAX_WIDTH + col] = mid;
		line_mem[col] = sample;
		fresh[0] = top;
		fresh[1] = mid;
		fresh[2] = sample;
		for (int r = 0; r < 3; r++) begin
			win[r*3 + 0] = win[r*3 + 1];
			win[r*3 + 1] = win[r*3 + 2];
			win[r*3 + 2] = fresh[r];
		end
		if (in_col + 1 >= w) begin
			in_col = 0;
			if (in_row < MAX_HEIGHT + 2) in_row++;
		end else begin
			in_col++;
		end
		if (!primed) return;

		sum = 0;
		cnt = 0;
		last = 1'b0;
		for (int r = 0; r < 3; r++) begin
			if (!cell_in_frame(out_row, r - 1, h)) continue;
			for (int c = 0; c < 3; c++) begin
				if (!cell_in_frame(out_col, c - 1, w)) continue;
				sum += win[r*3 + c];
				cnt++;
			end
		end
		if (out_col + 1 >= w) begin
			out_col = 0;
			if (out_row + 1 >= h) last = 1'b1;
			else out_row++;
		end else begin
			out_col++;
		end
		if (last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			frames_done++;
		end
		px.smoothed = cnt ? 8'(sum / cnt) : 8'd0;
		px.last = last;
		expected_pixels.push_back(px);
	endfunction

	// output side: random stall bursts, plus long holds on request
	always begin
		@(posedge clk);
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			repeat (rx_hold) @(posedge clk);
			rx_hold = 0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOWN)
					$display("unexpected output: smoothed %0d last %0b", m_tdata, m_tlast);
			end else begin
				oldest_px = expected_pixels.pop_front();
				if (m_tdata !== oldest_px.smoothed || m_tlast !== oldest_px.last) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOWN)
						$display("mismatch: smoothed exp %0d got %0d, last exp %0b got %0b",
							oldest_px.smoothed, m_tdata, oldest_px.last, m_tlast);
				end
			end
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] pix);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_blur(kind, pix);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		// items that cause no result may still be in flight
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_FRAME_WIDTH) frame_w_reg = val;
		else frame_h_reg = val;
	endtask

	task automatic set_size(input logic [CNT_W-1:0] w, input logic [CNT_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// fill: -1 random, -2 checkerboard of 0/255, else constant pixel
	task automatic send_frame(input int noise_pct, input int fill);
		int unsigned w, h;
		logic [7:0]  pix;
		logic        kind;
		w = clamp_size(frame_w_reg, MAX_WIDTH);
		h = clamp_size(frame_h_reg, MAX_HEIGHT);
		for (int unsigned i = 0; i < w*h; i++) begin
			if (fill == -1) pix = 8'($urandom_range(0, 255));
			else if (fill == -2) pix = ((i % w + i / w) % 2) ? 8'd255 : 8'd0;
			else pix = 8'(fill);
			kind = ($urandom_range(0, 99) < noise_pct) ? KIND_FLUSH : KIND_PIXEL;
			send_item(kind, pix);
		end
		for (int unsigned i = 0; i <= w; i++) begin
			kind = ($urandom_range(0, 99) < noise_pct) ? KIND_PIXEL : KIND_FLUSH;
			send_item(kind, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic finish_frame();
		int unsigned start_count;
		start_count = frames_done;
		while (frames_done == start_count)
			send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	// a full-width frame first, so every line store entry holds data afterwards;
	// oversize width acts as the maximum, zero height as one
	task automatic test_full_width();
		set_size(9'd511, 9'd0);
		send_frame(0, -1);
		wait_idle();
	endtask

	task automatic test_value_extremes();
		set_size(9'd3, 9'd3);
		send_frame(0, 255);
		wait_idle();
		set_size(9'd4, 9'd2);
		send_frame(0, -2);
		wait_idle();
	endtask

	task automatic test_size_limits();
		set_size(9'd1, 9'd1);
		send_frame(0, -1);
		wait_idle();
		set_size(9'd1, 9'd4);
		send_frame(0, -1);
		wait_idle();
		set_size(9'd5, 9'd1);
		send_frame(0, -1);
		wait_idle();
		// zero width acts as one
		set_size(9'd0, 9'd3);
		send_frame(0, -1);
		wait_idle();
	endtask

	task automatic test_odd_kinds();
		// flush items inside the image, pixels in the tail
		set_size(9'd3, 9'd3);
		send_frame(50, -1);
		wait_idle();
		set_size(9'd4, 9'd3);
		send_frame(100, 255);
		wait_idle();
	endtask

	task automatic test_midframe_resize();
		// width shrink past the output column: no cell left in frame
		set_size(9'd6, 9'd4);
		repeat (15) send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 9'd1);
		finish_frame();
		wait_idle();
		// height shrink ends the frame early
		set_size(9'd5, 9'd5);
		repeat (15) send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 9'd2);
		finish_frame();
		wait_idle();
		set_size(9'd3, 9'd4);
		repeat (5) send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 9'd7);
		write_reg(REG_FRAME_HEIGHT, 9'd6);
		finish_frame();
		wait_idle();
	endtask

	task automatic test_output_stall();
		set_size(9'd10, 9'd6);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b1;
		rx_hold = 300;
		send_frame(0, -1);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int unsigned goal, w, h, mode;
		logic [CNT_W-1:0] wv, hv;
		bit ragged;
		goal = items_sent + 80;
		ragged = 1'b0;
		while (items_sent < goal) begin
			wait_idle();
			if (goal - items_sent < 30) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end else begin
				tx_idle_en = $urandom_range(0, 3) != 0;
				rx_idle_en = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 24) == 0) begin
				wv = 9'($urandom_range(100, 256));
				hv = 9'($urandom_range(1, 2));
			end else begin
				wv = 9'($urandom_range(1, 12));
				hv = 9'($urandom_range(1, 6));
			end
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: wv = 9'd0;
					1: hv = 9'd0;
					2: begin
						wv = 9'($urandom_range(257, 511));
						hv = 9'($urandom_range(1, 2));
					end
					default: begin
						hv = 9'($urandom_range(257, 511));
						wv = 9'($urandom_range(0, 1));
					end
				endcase
			end
			// sometimes keep one size, when that keeps the frame small
			if (!(clamp_size(frame_w_reg, MAX_WIDTH) <= 12 && hv <= 6
					&& $urandom_range(0, 5) == 0))
				write_reg(REG_FRAME_WIDTH, wv);
			if (!(clamp_size(frame_h_reg, MAX_HEIGHT) <= 6 && wv <= 12
					&& $urandom_range(0, 5) == 0))
				write_reg(REG_FRAME_HEIGHT, hv);
			if (ragged) begin
				finish_frame();
				ragged = 1'b0;
				continue;
			end
			w = clamp_size(frame_w_reg, MAX_WIDTH);
			h = clamp_size(frame_h_reg, MAX_HEIGHT);
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				send_frame(mode == 0 ? 20 : 3, -1);
			end else if (mode == 7) begin
				// truncated frame, resized while still open
				repeat ($urandom_range(1, w*h + w))
					send_item($urandom_range(0, 9) == 0 ? KIND_FLUSH : KIND_PIXEL,
						8'($urandom_range(0, 255)));
				ragged = 1'b1;
			end else if (mode == 8) begin
				send_frame(3, -1);
				repeat ($urandom_range(1, 5))
					send_item(KIND_PIXEL, 8'($urandom_range(0, 255)));
				ragged = 1'b1;
			end else begin
				send_frame(50, -1);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_width();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_value_extremes();
		test_size_limits();
		test_odd_kinds();
		test_midframe_resize();
		test_output_stall();
		test_random_frames();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
